// File: rtl/spre_pkg.sv
// ----------------------------------------------------------------------------
// spre_pkg
// Shared types, codes and reset values for the servo pulse range expander.
// ----------------------------------------------------------------------------
package spre_pkg;

	// Default width of the tick counter
	localparam int COUNT_BITS_DEF = 16;

	// Stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 2;

	// Config reset values
	localparam logic [15:0] IN_MIN_RST  = 16'd1200;
	localparam logic [15:0] IN_MAX_RST  = 16'd2400;
	localparam logic [15:0] MID_RST     = 16'd1800;
	localparam logic [15:0] OUT_MIN_RST = 16'd600;
	localparam logic [15:0] OUT_MAX_RST = 16'd3000;
	localparam logic [14:0] MID_DIV3_RST = 15'd600;
	localparam logic [1:0]  MID_REM_RST  = 2'd0;

	// floor(x/3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for any 16-bit x
	localparam logic [16:0] DIV3_RECIP = 17'd43691;
	localparam int          DIV3_SHIFT = 17;

	typedef enum logic [2:0] {
		REG_IN_MIN  = 3'd0,
		REG_IN_MAX  = 3'd1,
		REG_MID     = 3'd2,
		REG_OUT_MIN = 3'd3,
		REG_OUT_MAX = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_MEASURE = 2'd1,
		PH_GEN     = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_REJECT = 2'd2
	} event_t;

	typedef struct packed {
		logic [15:0] in_min;
		logic [15:0] in_max;
		logic [15:0] mid;
		logic [14:0] mid_div3;
		logic [1:0]  mid_rem;
		logic [15:0] out_min;
		logic [15:0] out_max;
	} cfg_t;

endpackage

// File: rtl/spre_cfg.sv
// ----------------------------------------------------------------------------
// spre_cfg
// Config register file; also keeps the midpoint split into quotient and
// remainder by three for the expansion datapath.
// ----------------------------------------------------------------------------
module spre_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	output spre_pkg::cfg_t     cfg
);

	logic [15:0] in_min_q;
	logic [15:0] in_max_q;
	logic [15:0] mid_q;
	logic [14:0] mid_div3_q;
	logic [1:0]  mid_rem_q;
	logic [15:0] out_min_q;
	logic [15:0] out_max_q;
	logic [31:0] div_prod;
	logic [14:0] div_q;
	logic [1:0]  div_x3_lo;

	assign div_prod = 32'(cfg_wdata) * 32'(spre_pkg::DIV3_RECIP);
	assign div_q    = div_prod[spre_pkg::DIV3_SHIFT+14:spre_pkg::DIV3_SHIFT];
	// low two bits of 3*q; the remainder fits in two bits
	assign div_x3_lo = {div_q[0], 1'b0} + div_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_min_q   <= spre_pkg::IN_MIN_RST;
			in_max_q   <= spre_pkg::IN_MAX_RST;
			mid_q      <= spre_pkg::MID_RST;
			mid_div3_q <= spre_pkg::MID_DIV3_RST;
			mid_rem_q  <= spre_pkg::MID_REM_RST;
			out_min_q  <= spre_pkg::OUT_MIN_RST;
			out_max_q  <= spre_pkg::OUT_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spre_pkg::REG_IN_MIN:  in_min_q  <= cfg_wdata;
				spre_pkg::REG_IN_MAX:  in_max_q  <= cfg_wdata;
				spre_pkg::REG_MID: begin
					mid_q      <= cfg_wdata;
					mid_div3_q <= div_q;
					mid_rem_q  <= cfg_wdata[1:0] - div_x3_lo;
				end
				spre_pkg::REG_OUT_MIN: out_min_q <= cfg_wdata;
				spre_pkg::REG_OUT_MAX: out_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.in_min   = in_min_q;
	assign cfg.in_max   = in_max_q;
	assign cfg.mid      = mid_q;
	assign cfg.mid_div3 = mid_div3_q;
	assign cfg.mid_rem  = mid_rem_q;
	assign cfg.out_min  = out_min_q;
	assign cfg.out_max  = out_max_q;

endmodule

// File: rtl/spre_expand.sv
// ----------------------------------------------------------------------------
// spre_expand
// Expands a measured width about the midpoint and clamps to the output window.
// r = 2w - mid + 2*s, s = signed quotient difference of w and mid by three.
// ----------------------------------------------------------------------------
module spre_expand #(
	parameter int COUNT_BITS = spre_pkg::COUNT_BITS_DEF
) (
	input  logic [COUNT_BITS-1:0] width,
	input  logic [COUNT_BITS-1:0] width_div3,
	input  logic [1:0]            width_rem,
	input  spre_pkg::cfg_t        cfg,
	output logic [15:0]           out_width
);

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int RW    = CMP_W + 4;

	logic signed [RW-1:0] w_e;
	logic signed [RW-1:0] qw_e;
	logic signed [RW-1:0] mid_e;
	logic signed [RW-1:0] qm_e;
	logic signed [RW-1:0] qs;
	logic signed [RW-1:0] r;
	logic signed [RW-1:0] lo;
	logic signed [RW-1:0] hi;
	logic signed [RW-1:0] r_lo;
	logic signed [RW-1:0] r_cl;
	logic                 below_mid;

	assign w_e   = signed'({{(RW-COUNT_BITS){1'b0}}, width});
	assign qw_e  = signed'({{(RW-COUNT_BITS){1'b0}}, width_div3});
	assign mid_e = signed'({{(RW-16){1'b0}}, cfg.mid});
	assign qm_e  = signed'({{(RW-15){1'b0}}, cfg.mid_div3});
	assign lo    = signed'({{(RW-16){1'b0}}, cfg.out_min});
	assign hi    = signed'({{(RW-16){1'b0}}, cfg.out_max});

	assign below_mid = (w_e < mid_e);

	// floor of |w - mid| / 3 from the split forms, with sign folded in
	always_comb begin
		if (below_mid) begin
			qs = qw_e - qm_e + RW'(cfg.mid_rem < width_rem);
		end else begin
			qs = qw_e - qm_e - RW'(width_rem < cfg.mid_rem);
		end
	end

	assign r    = (w_e <<< 1) - mid_e + (qs <<< 1);
	assign r_lo = (r < lo) ? lo : r;
	assign r_cl = (r_lo > hi) ? hi : r_lo;

	assign out_width = r_cl[15:0];

endmodule

// File: rtl/spre_core.sv
// ----------------------------------------------------------------------------
// spre_core
// Input register, pulse measure/generate state machine and result register.
// ----------------------------------------------------------------------------
module spre_core #(
	parameter int COUNT_BITS = spre_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spre_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_level,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_servo,
	output logic [1:0]     out_event,
	output logic [15:0]    out_width
);

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	// stage 1: captured tick
	logic valid_s1;
	logic level_s1;
	// stage 2: result beat
	logic                  valid_s2;
	logic                  servo_s2;
	spre_pkg::event_t      event_s2;
	logic [15:0]           width_s2;

	spre_pkg::phase_t      phase_q, phase_nx;
	logic                  prev_q, prev_nx;
	logic [COUNT_BITS-1:0] cnt_q, cnt_nx, cnt_p1;
	logic [COUNT_BITS-1:0] cq_q, cq_nx, cq_p1;
	logic [1:0]            cr_q, cr_nx, cr_p1;
	logic [15:0]           target_q, target_nx;

	logic                  servo_nx;
	spre_pkg::event_t      event_nx;
	logic [15:0]           width_nx;

	logic                  advance;
	logic                  sat;
	logic                  out_of_win;
	logic [15:0]           exp_width;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	spre_expand #(
		.COUNT_BITS(COUNT_BITS)
	) u_expand (
		.width      (cnt_q),
		.width_div3 (cq_q),
		.width_rem  (cr_q),
		.cfg        (cfg),
		.out_width  (exp_width)
	);

	// saturating counter with running quotient/remainder by three
	assign sat    = (cnt_q == {COUNT_BITS{1'b1}});
	assign cnt_p1 = sat ? cnt_q : cnt_q + COUNT_BITS'(1);
	assign cq_p1  = (!sat && cr_q == 2'd2) ? cq_q + COUNT_BITS'(1) : cq_q;
	assign cr_p1  = sat ? cr_q : ((cr_q == 2'd2) ? 2'd0 : cr_q + 2'd1);

	assign out_of_win = (CMP_W'(cnt_q) < CMP_W'(cfg.in_min)) ||
	                    (CMP_W'(cnt_q) > CMP_W'(cfg.in_max));

	always_comb begin
		phase_nx  = phase_q;
		prev_nx   = level_s1;
		cnt_nx    = cnt_q;
		cq_nx     = cq_q;
		cr_nx     = cr_q;
		target_nx = target_q;
		servo_nx  = 1'b0;
		event_nx  = spre_pkg::EV_NONE;
		width_nx  = '0;
		unique case (phase_q)
			spre_pkg::PH_MEASURE: begin
				if (level_s1) begin
					cnt_nx = cnt_p1;
					cq_nx  = cq_p1;
					cr_nx  = cr_p1;
				end else if (out_of_win) begin
					event_nx = spre_pkg::EV_REJECT;
					phase_nx = spre_pkg::PH_WAIT;
				end else begin
					event_nx  = spre_pkg::EV_ACCEPT;
					width_nx  = exp_width;
					target_nx = exp_width;
					cnt_nx    = '0;
					cq_nx     = '0;
					cr_nx     = 2'd0;
					phase_nx  = (exp_width != 16'd0) ? spre_pkg::PH_GEN : spre_pkg::PH_WAIT;
				end
			end
			spre_pkg::PH_GEN: begin
				servo_nx = 1'b1;
				cnt_nx   = cnt_p1;
				cq_nx    = cq_p1;
				cr_nx    = cr_p1;
				if (CMP_W'(cnt_p1) >= CMP_W'(target_q)) begin
					phase_nx = spre_pkg::PH_WAIT;
				end
			end
			default: begin
				// waiting; the unused code behaves the same
				phase_nx = spre_pkg::PH_WAIT;
				if (level_s1 && !prev_q) begin
					cnt_nx   = COUNT_BITS'(1);
					cq_nx    = '0;
					cr_nx    = 2'd1;
					phase_nx = spre_pkg::PH_MEASURE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= spre_pkg::PH_WAIT;
			prev_q   <= 1'b1;
			cnt_q    <= '0;
			cq_q     <= '0;
			cr_q     <= 2'd0;
			target_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_nx;
			prev_q   <= prev_nx;
			cnt_q    <= cnt_nx;
			cq_q     <= cq_nx;
			cr_q     <= cr_nx;
			target_q <= target_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= in_level;
		end
		if (advance) begin
			servo_s2 <= servo_nx;
			event_s2 <= event_nx;
			width_s2 <= width_nx;
		end
	end

	assign out_valid = valid_s2;
	assign out_servo = servo_s2;
	assign out_event = event_s2;
	assign out_width = width_s2;

endmodule

// File: rtl/servo_pulse_range_expander_unit.sv
// ----------------------------------------------------------------------------
// servo_pulse_range_expander_unit
// Servo pulse width range expander: measures input pulses, widens them about
// a midpoint and regenerates them on the output.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one beat per timer tick, tdata[0] = sampled servo input.
//  - Master stream: one beat per input beat, in order. tdata[0] = output pin
//    level, tdata[16:1] = expanded width (nonzero only on an accept event),
//    tuser = event code (none / pulse accepted / pulse rejected).
//  - Config: cfg_we writes cfg_wdata to register cfg_index;
//    0 in_min, 1 in_max, 2 mid, 3 out_min, 4 out_max. Write only while no
//    beat is in flight; the next beat already sees the new value.
//  - Throughput: one beat per clock while the master side keeps tready high.
//    An accepted input beat passes the input register, then the result
//    register; the state machine and the expansion datapath sit between the two.
//  - The expansion needs no divider: the tick counter carries its quotient
//    and remainder by three as it counts, the midpoint is split at write.
//  - Reset: no beats pending, config at its defaults, waiting for a rising
//    edge with the previous level taken as high.
//  - Stall: if the master side holds tready low, one result and one input
//    beat are held; the slave side then drops tready, nothing is lost.
// ----------------------------------------------------------------------------
module servo_pulse_range_expander_unit #(
	parameter int COUNT_BITS = spre_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [15:0]                      cfg_wdata,
	// tick input
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [spre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [0] in_level
	// result output
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [spre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [0] level_out, [16:1] out_width
	output logic [spre_pkg::OUT_TUSER_W-1:0] m_axis_tuser    // [1:0] event_code
);

	spre_pkg::cfg_t cfg;
	logic           level_out;
	logic [1:0]     event_code;
	logic [15:0]    out_width;

	spre_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// the upper tdata bits of the slave side are padding
	spre_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_level  (s_axis_tdata[0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_servo (level_out),
		.out_event (event_code),
		.out_width (out_width)
	);

	assign m_axis_tdata = {{(spre_pkg::OUT_TDATA_W-17){1'b0}}, out_width, level_out};
	assign m_axis_tuser = event_code;

endmodule

// File: rtl/spre_checker.sv
// ----------------------------------------------------------------------------
// spre_checker
// Port-level checks for the servo pulse range expander.
// ----------------------------------------------------------------------------
module spre_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [spre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [spre_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

	// a held result beat keeps its content
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// the event code is one of the three defined codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined event code");

	// the output is low on the tick that reports a measured pulse
	a_evt_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == spre_pkg::EV_ACCEPT ||
			m_axis_tuser == spre_pkg::EV_REJECT) |-> !m_axis_tdata[0])
		else $error("output pin high on an event tick");

	// width is only reported with an accept event
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != spre_pkg::EV_ACCEPT |-> m_axis_tdata[16:1] == 16'd0)
		else $error("width shown without accept event");

	// an input beat is taken only while there is room, so a full pipe backs up
	a_backpr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && $past(m_axis_tvalid && !m_axis_tready) &&
			$past(s_axis_tvalid && s_axis_tready) |-> !s_axis_tready)
		else $error("input taken with both stages full");

endmodule

bind servo_pulse_range_expander_unit spre_checker u_spre_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_servo_pulse_range_expander_unit.sv
// ----------------------------------------------------------------------------
// tb_servo_pulse_range_expander_unit
// Self-checking bench for the servo pulse range expander: drives tick beats,
// mirrors the measure / expand / regenerate behavior in a local tracker and
// checks every result beat in order, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_servo_pulse_range_expander_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spre_pkg::*;

	// no handshake on either side for this many cycles ends the run
	localparam int WATCHDOG_LIMIT = 2000;
	// saturation point of the tick counter at the default width
	localparam logic [COUNT_BITS_DEF-1:0] CNT_MAX = '1;

	typedef enum int {
		RX_FULL,
		RX_CHOPPY,
		RX_SPARSE
	} rx_mode_t;

	// one result beat as the tracker predicts it
	typedef struct packed {
		logic        level_out;
		event_t      ev;
		logic [15:0] width;
	} out_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [2:0]             cfg_index = REG_IN_MIN;
	logic [15:0]            cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] in_level
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] level_out, [16:1] out_width
	logic [OUT_TUSER_W-1:0] m_axis_tuser;        // [1:0] event_code

	servo_pulse_range_expander_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Pulse tracker: local copy of window registers and measuring state
	// ------------------------------------------------------------------
	logic [15:0]               win_in_min  = IN_MIN_RST;
	logic [15:0]               win_in_max  = IN_MAX_RST;
	logic [15:0]               win_mid     = MID_RST;
	logic [15:0]               win_out_min = OUT_MIN_RST;
	logic [15:0]               win_out_max = OUT_MAX_RST;

	phase_t                    trk_phase  = PH_WAIT;
	logic                      trk_prev   = 1'b1;   // reset: no false edge
	logic [COUNT_BITS_DEF-1:0] trk_count  = '0;
	logic [15:0]               trk_target = '0;

	out_beat_t pending_out_beats[$];
	int        live_ticks = 0;      // ticks outside output generation
	int        mismatches = 0;
	int        burst_left = 0;

	// widen w about the midpoint (signed), then clamp low first, high second
	function automatic logic [15:0] expand_pulse_width(input logic [15:0] w);
		int mid_i;
		int d;
		int mag;
		int r;
		mid_i = int'(win_mid);
		d = int'(w);
		d = d - mid_i;
		mag = (d < 0) ? -d : d;
		r = 2 * mag + 2 * (mag / 3);
		r = (d < 0) ? mid_i - r : mid_i + r;
		if (r < int'(win_out_min)) r = int'(win_out_min);
		if (r > int'(win_out_max)) r = int'(win_out_max);
		return 16'(r);
	endfunction

	// advance the tracker by one accepted tick and queue its result beat
	function automatic void step_pulse_tracker(input logic level);
		out_beat_t res;
		res = '{level_out: 1'b0, ev: EV_NONE, width: 16'd0};
		if (trk_phase != PH_GEN) live_ticks++;
		case (trk_phase)
			PH_MEASURE: begin
				if (level) begin
					if (trk_count != CNT_MAX) trk_count++;
				end else if (trk_count < win_in_min || trk_count > win_in_max) begin
					res.ev = EV_REJECT;
					trk_phase = PH_WAIT;
				end else begin
					res.width = expand_pulse_width(trk_count);
					res.ev = EV_ACCEPT;
					trk_target = res.width;
					trk_count = '0;
					trk_phase = (res.width != 16'd0) ? PH_GEN : PH_WAIT;
				end
			end
			PH_GEN: begin
				// input ignored here, only the previous level follows it
				res.level_out = 1'b1;
				if (trk_count != CNT_MAX) trk_count++;
				if (trk_count >= trk_target) trk_phase = PH_WAIT;
			end
			default: begin
				trk_phase = PH_WAIT;
				if (level && !trk_prev) begin
					trk_count = COUNT_BITS_DEF'(1);   // the edge tick is the first high tick
					trk_phase = PH_MEASURE;
				end
			end
		endcase
		trk_prev = level;
		pending_out_beats.push_back(res);
	endfunction

	// ------------------------------------------------------------------
	// Sender side: bursts of beats with random gaps in between
	// ------------------------------------------------------------------
	task automatic send_tick(input logic level);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			// about one burst in four follows the last without a gap
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, level};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		step_pulse_tracker(level);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_level(input logic level, input int count);
		repeat (count) send_tick(level);
	endtask

	// lows, then a high stretch of the given width, then the falling tick
	task automatic send_pulse(input int width, input int lows_before);
		send_level(1'b0, lows_before);
		send_level(1'b1, width);
		send_tick(1'b0);
	endtask

	// feed lows until the regenerated output pulse is over
	task automatic finish_output_pulse();
		while (trk_phase == PH_GEN) send_tick(1'b0);
	endtask

	task automatic measure_pulse(input int width);
		send_pulse(width, 2);
		finish_output_pulse();
	endtask

	// hold the sender until every queued result beat has come back
	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		while (pending_out_beats.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);   // margin after the last result beat
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_IN_MIN:  win_in_min  = value;
			REG_IN_MAX:  win_in_max  = value;
			REG_MID:     win_mid     = value;
			REG_OUT_MIN: win_out_min = value;
			REG_OUT_MAX: win_out_max = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// all five window registers, written only with the block drained
	task automatic load_windows(input logic [15:0] in_lo, input logic [15:0] in_hi,
			input logic [15:0] mid, input logic [15:0] out_lo, input logic [15:0] out_hi);
		wait_results_done();
		write_reg(REG_IN_MIN, in_lo);
		write_reg(REG_IN_MAX, in_hi);
		write_reg(REG_MID, mid);
		write_reg(REG_OUT_MIN, out_lo);
		write_reg(REG_OUT_MAX, out_hi);
		cfg_we <= 1'b0;
		// short idle stretch before traffic resumes
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver side: tready pattern switching among three modes
	// ------------------------------------------------------------------
	rx_mode_t rx_mode = RX_FULL;
	int       rx_hold = 0;

	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_hold = $urandom_range(16, 160);
		end else begin
			rx_hold--;
		end
		case (rx_mode)
			RX_FULL:   m_axis_tready <= 1'b1;
			RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default:   m_axis_tready <= (rx_hold % 4 == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Result checker: each result beat against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_beats
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_out_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with none expected: tdata=%h tuser=%h",
						$realtime, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_out_beats.pop_front();
				if (m_axis_tdata[0] !== want.level_out || m_axis_tuser !== want.ev ||
						m_axis_tdata[16:1] !== want.width ||
						m_axis_tdata[OUT_TDATA_W-1:17] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: beat mismatch: want out=%0b ev=%0d width=%0d, ",
							"got out=%0b ev=%0d width=%0d pad=%0h"}, $realtime,
							want.level_out, want.ev, want.width, m_axis_tdata[0],
							m_axis_tuser, m_axis_tdata[16:1],
							m_axis_tdata[OUT_TDATA_W-1:17]);
				end
			end
		end
	end

	// watchdog: cycles without a handshake on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_servo_pulse_range_expander_unit: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset windows: high level right after reset is no edge; short pulses
	// fall below the reset input window and are rejected
	task automatic test_default_windows();
		send_level(1'b1, 3);
		send_level(1'b0, 2);
		measure_pulse(5);
		measure_pulse(40);
	endtask

	// small windows: edges of the input window, d = 0 and each d mod 3
	task automatic test_window_edges();
		load_windows(16'd4, 16'd12, 16'd8, 16'd2, 16'd30);
		measure_pulse(3);
		measure_pulse(4);
		measure_pulse(12);
		measure_pulse(13);
		for (int w = 5; w <= 11; w++) measure_pulse(w);
	endtask

	// input held high through the output pulse: no edge when it ends
	task automatic test_input_ignored_during_output();
		send_pulse(12, 2);          // 18-tick output pulse
		send_level(1'b1, 25);
		send_level(1'b0, 1);
		send_pulse(6, 0);
		send_level(1'b1, 3);        // rising mid-output, also ignored
		send_level(1'b0, 2);
		finish_output_pulse();
		send_level(1'b0, 2);
	endtask

	task automatic test_clamp_corners();
		// crossed output window: upper clamp wins
		load_windows(16'd2, 16'd20, 16'd8, 16'd20, 16'd10);
		measure_pulse(4);
		measure_pulse(15);
		// zero output width: accepted, no pulse, next edge taken at once
		load_windows(16'd1, 16'd10, 16'd5, 16'd0, 16'd0);
		send_pulse(5, 2);
		send_pulse(7, 0);
		finish_output_pulse();
		// crossed input window: every pulse rejected
		load_windows(16'd10, 16'd5, 16'd8, 16'd0, 16'd40);
		measure_pulse(5);
		measure_pulse(7);
		measure_pulse(10);
		// far below a top midpoint: signed result goes negative, lower clamp
		load_windows(16'd0, 16'hFFFF, 16'hFFFF, 16'd7, 16'd9);
		measure_pulse(1);
		measure_pulse(3);
	endtask

	// random windows; mostly well-formed pulses near the input window, the
	// rest random levels and pulses cut short by output generation
	task automatic test_random_pulses();
		logic [15:0] lo;
		logic [15:0] hi;
		int          wlo;
		int          whi;
		int          start;
		bit          paused;
		paused = 1'b0;
		for (int ph = 0; ph < 5; ph++) begin
			lo = 16'($urandom_range(1, 10));
			hi = lo + 16'($urandom_range(0, 15));
			if ($urandom_range(0, 5) == 0) begin
				wlo = int'(lo);
				lo  = hi + 16'd1;
				hi  = 16'(wlo);
			end
			load_windows(lo, hi, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 10)),
				16'($urandom_range(0, 60)));
			wlo = (lo < hi) ? int'(lo) : int'(hi);
			whi = (lo < hi) ? int'(hi) : int'(lo);
			start = live_ticks;
			while (live_ticks - start < 60) begin
				if (ph == 2 && !paused && live_ticks - start >= 30) begin
					wait_results_done();
					paused = 1'b1;
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
				end else begin
					send_pulse($urandom_range((wlo > 2) ? wlo - 2 : 1, whi + 2),
						$urandom_range(0, 4));
					if ($urandom_range(0, 3) != 0) finish_output_pulse();
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_windows();
		test_window_edges();
		test_input_ignored_during_output();
		test_clamp_corners();
		test_random_pulses();

		wait_results_done();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_out_beats.size() == 0) begin
			$display("tb_servo_pulse_range_expander_unit: PASS");
		end else begin
			$display("tb_servo_pulse_range_expander_unit: FAIL");
		end
		$finish;
	end

endmodule
